FILE: hdl/crc16me_pkg.sv
`default_nettype none

package crc16me_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // One byte of MSB-first CRC-16: the byte goes into the high half, then
    // eight shift steps fold the polynomial in where the top bit falls out.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/crc16_msb_first_engine_core.sv
// A checksum is registered into the result register, or into the skid register while the output stalls.
// Throughput: one byte per cycle while o_stall is low; the byte update is one eight-step xor network.
// A two-deep output (result register plus skid register) keeps input flowing
// while the downstream side stalls; input stalls only when both are full.
// Reset (i_rst_n low, synchronous) loads the CRC register with 0xFFFF and empties the output.
`default_nettype none

module crc16_msb_first_engine_core
    import crc16me_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_checksum
);

    logic [15:0] r_crc;
    logic [15:0] r_out;
    logic [15:0] r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;

    logic        in_acc;
    logic        out_free;
    logic        new_result;
    logic [15:0] crc_next;
    logic [15:0] result;

    assign o_stall    = r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_checksum = r_out;

    assign in_acc     = i_valid & ~r_skid_valid;
    assign out_free   = ~r_out_valid | ~i_stall;
    assign crc_next   = crc16_byte(r_crc, i_data_byte);
    assign new_result = in_acc & i_last_byte;
    assign result     = crc_next ^ CRC_XOROUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_crc <= i_last_byte ? CRC_INIT : crc_next;
            end
            // Input is stalled while the skid register holds a word, so a
            // fresh result and a skid drain never meet in the same cycle.
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= new_result;
                    if (new_result) begin
                        r_out <= result;
                    end
                end
            end else if (new_result) begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/crc16me_checker.sv
`default_nettype none

module crc16me_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_data_byte,
    input wire logic        i_last_byte,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_checksum
);

    // A waiting checksum holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_checksum)))
        else $error("stalled checksum changed or dropped");

    // Input stalls only while a checksum is already waiting on the output.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output");

    // After an accepted last byte, the output always holds a checksum in the next cycle.
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_byte) |=> o_valid)
        else $error("last byte produced no checksum");

    // A byte that is not last never invents a checksum on an empty output.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_last_byte && !o_valid) |=> !o_valid)
        else $error("checksum without a last byte");

    // Leaving reset, the output is empty and input is open.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("output not empty after reset");

endmodule

bind crc16_msb_first_engine_core crc16me_checker u_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import crc16me_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_msg_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_checksum;

    t_msg_word   pending_words[$];
    logic [15:0] expected_checksums[$];
    logic [15:0] running_crc = CRC_INIT;
    t_msg_word   offered_word;
    logic        word_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int          hold_left = 0;
    int          error_count = 0;

    crc16_msb_first_engine_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_checksum  (o_checksum)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bit-serial form of the MSB-first update: each data bit meets the
    // register's top bit, and their sum decides whether the polynomial folds in.
    function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ data[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string note, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: %s: got 0x%04h, expected 0x%04h", $time, note, got, want);
        error_count++;
    endtask

    task automatic add_byte(input logic [7:0] data, input logic last);
        t_msg_word w;
        w.data = data;
        w.last = last;
        pending_words.push_back(w);
    endtask

    // Messages are mostly short, with an occasional long one.
    task automatic add_random_messages(input int word_total);
        int n;
        int len;
        n = 0;
        while (n < word_total) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(40, 7);
            end else begin
                len = $urandom_range(6, 1);
            end
            for (int k = 0; k < len; k++) begin
                add_byte(8'($urandom_range(255)), k == len - 1);
            end
            n += len;
        end
    endtask

    task automatic wait_drained;
        while (pending_words.size() > 0 || i_valid || expected_checksums.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // Input acceptance, checksum prediction and output checking all sample
    // at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            running_crc = CRC_INIT;
        end else begin
            if (i_valid && !o_stall) begin
                running_crc = crc_after_byte(running_crc, i_data_byte);
                if (i_last_byte) begin
                    expected_checksums.push_back(running_crc ^ CRC_XOROUT);
                    running_crc = CRC_INIT;
                end
            end
            if (o_valid && !i_stall) begin
                if (expected_checksums.size() == 0) begin
                    report_mismatch("checksum with no message pending", o_checksum, 16'h0000);
                end else if (o_checksum !== expected_checksums[0]) begin
                    report_mismatch("checksum mismatch", o_checksum, expected_checksums[0]);
                    void'(expected_checksums.pop_front());
                end else begin
                    void'(expected_checksums.pop_front());
                end
            end
        end
    end

    // Sender: a word stays on the bus until taken, then the next one may
    // follow at once or after a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_word = pending_words.pop_front();
                i_valid     <= 1'b1;
                i_data_byte <= offered_word.data;
                i_last_byte <= offered_word.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that fills the output
    // buffer and pushes back on the input side.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 80;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        string check_str;
        check_str = "123456789";

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed messages: single-byte extremes, lone top and bottom bits,
        // the usual check string, all-ones run and alternating patterns.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b1);
        for (int i = 0; i < 9; i++) begin
            add_byte(check_str[i], i == 8);
        end
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b1);
        wait_drained();

        send_idle_pct = 17;
        recv_idle_pct = 66;
        add_random_messages(300);
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 17;
        add_random_messages(300);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_messages(300);
        long_hold_req = 1'b1;
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
